FILE: hdl/uvsig_pkg.sv
package uvsig_pkg;

    localparam int unsigned MAX_DIVISIONS = 255;
    localparam int unsigned MIN_DIVISIONS = 3;

    localparam int unsigned DIV_W   = 8;
    localparam int unsigned INDEX_W = 16;

    localparam logic [DIV_W-1:0] LAT_DIV_RESET  = DIV_W'(12);
    localparam logic [DIV_W-1:0] LONG_DIV_RESET = DIV_W'(24);

    // Configuration register indexes.
    localparam logic REG_LAT_DIV  = 1'b0;
    localparam logic REG_LONG_DIV = 1'b1;

    typedef enum logic [1:0] {
        PH_BODY_A = 2'd0,
        PH_BODY_B = 2'd1,
        PH_NORTH  = 2'd2,
        PH_SOUTH  = 2'd3
    } t_phase;

    // Clamp a division count into the supported range.
    function automatic logic [DIV_W-1:0] eff_div(input logic [DIV_W-1:0] v);
        logic [DIV_W:0] wide;
        wide = {1'b0, v};
        if (wide < (DIV_W+1)'(MIN_DIVISIONS)) begin
            return DIV_W'(MIN_DIVISIONS);
        end else if (wide > (DIV_W+1)'(MAX_DIVISIONS)) begin
            return DIV_W'(MAX_DIVISIONS);
        end
        return v;
    endfunction

endpackage

FILE: hdl/uv_sphere_index_generator.sv
// An accepted item's triangle is written to the output register in the cycle after it is taken.
// Throughput: one triangle per cycle; the next item is taken while a result is
// being handed over, so only a stalled output holds the input back.
// The critical path is one 8x8 multiply for the pole index feeding a 16-bit add.
// Reset (synchronous, active low) restores the division registers to 12 and 24,
// clears the mesh counters to the first body triangle and empties the output.
module uv_sphere_index_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic                              i_cfg_index,
    input  logic [uvsig_pkg::DIV_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_restart,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [uvsig_pkg::INDEX_W-1:0]     o_index_a,
    output logic [uvsig_pkg::INDEX_W-1:0]     o_index_b,
    output logic [uvsig_pkg::INDEX_W-1:0]     o_index_c,
    output logic                              o_last_triangle
);

    localparam int unsigned DW = uvsig_pkg::DIV_W;
    localparam int unsigned IW = uvsig_pkg::INDEX_W;

    logic [DW-1:0]     r_lat_div;
    logic [DW-1:0]     r_long_div;
    uvsig_pkg::t_phase r_phase;
    uvsig_pkg::t_phase n_phase;
    logic [DW-1:0]     r_col;
    logic [DW-1:0]     n_col;
    logic [DW-1:0]     r_band;
    logic [DW-1:0]     n_band;
    logic [IW-1:0]     r_base;
    logic [IW-1:0]     n_base;
    logic              r_out_valid;
    logic [IW-1:0]     r_index_a;
    logic [IW-1:0]     r_index_b;
    logic [IW-1:0]     r_index_c;
    logic              r_last;

    logic              in_accept;
    logic [DW-1:0]     lat;
    logic [DW-1:0]     lon;
    uvsig_pkg::t_phase cur_phase;
    logic [DW-1:0]     cur_col;
    logic [DW-1:0]     cur_band;
    logic [IW-1:0]     cur_base;
    logic [DW-1:0]     col_next;
    logic              col_last;
    logic              band_last;
    logic [IW-1:0]     north;
    logic [IW-1:0]     south0;
    logic [IW-1:0]     lon_w;
    logic [IW-1:0]     col_w;
    logic [IW-1:0]     coln_w;
    logic [IW-1:0]     idx_a;
    logic [IW-1:0]     idx_b;
    logic [IW-1:0]     idx_c;
    logic              last;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    assign lat = uvsig_pkg::eff_div(r_lat_div);
    assign lon = uvsig_pkg::eff_div(r_long_div);

    // A restart item behaves as if the counters had just been cleared.
    assign cur_phase = i_restart ? uvsig_pkg::PH_BODY_A : r_phase;
    assign cur_col   = i_restart ? '0 : r_col;
    assign cur_band  = i_restart ? '0 : r_band;
    assign cur_base  = i_restart ? '0 : r_base;

    assign col_last  = cur_col >= (lon - DW'(1));
    assign col_next  = col_last ? '0 : cur_col + DW'(1);
    assign band_last = cur_band >= (lat - DW'(3));

    assign lon_w  = IW'(lon);
    assign col_w  = IW'(cur_col);
    assign coln_w = IW'(col_next);
    assign north  = IW'(lat - DW'(1)) * lon_w;
    assign south0 = north - lon_w;

    // Next state of the mesh walk.
    always_comb begin
        n_phase = cur_phase;
        n_col   = cur_col;
        n_band  = cur_band;
        n_base  = cur_base;
        unique case (cur_phase)
            uvsig_pkg::PH_BODY_A: begin
                n_phase = uvsig_pkg::PH_BODY_B;
            end
            uvsig_pkg::PH_BODY_B: begin
                n_phase = uvsig_pkg::PH_BODY_A;
                n_col   = col_next;
                if (col_last && band_last) begin
                    n_phase = uvsig_pkg::PH_NORTH;
                end else if (col_last) begin
                    n_band = cur_band + DW'(1);
                    n_base = cur_base + lon_w;
                end
            end
            uvsig_pkg::PH_NORTH: begin
                n_phase = uvsig_pkg::PH_SOUTH;
            end
            uvsig_pkg::PH_SOUTH: begin
                n_col = col_next;
                if (col_last) begin
                    n_phase = uvsig_pkg::PH_BODY_A;
                    n_band  = '0;
                    n_base  = '0;
                end else begin
                    n_phase = uvsig_pkg::PH_NORTH;
                end
            end
            default: begin
                n_phase = uvsig_pkg::PH_BODY_A;
            end
        endcase
    end

    // Triangle corners for the current step.
    always_comb begin
        last = 1'b0;
        unique case (cur_phase)
            uvsig_pkg::PH_BODY_A: begin
                idx_a = cur_base + col_w;
                idx_b = cur_base + lon_w + col_w;
                idx_c = cur_base + coln_w;
            end
            uvsig_pkg::PH_BODY_B: begin
                idx_a = cur_base + coln_w;
                idx_b = cur_base + lon_w + col_w;
                idx_c = cur_base + lon_w + coln_w;
            end
            uvsig_pkg::PH_NORTH: begin
                idx_a = north;
                idx_b = col_w;
                idx_c = coln_w;
            end
            uvsig_pkg::PH_SOUTH: begin
                idx_a = south0 + coln_w;
                idx_b = south0 + col_w;
                idx_c = north + IW'(1);
                last  = col_last;
            end
            default: begin
                idx_a = '0;
                idx_b = '0;
                idx_c = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_div  <= uvsig_pkg::LAT_DIV_RESET;
            r_long_div <= uvsig_pkg::LONG_DIV_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                uvsig_pkg::REG_LAT_DIV:  r_lat_div  <= i_cfg_data;
                uvsig_pkg::REG_LONG_DIV: r_long_div <= i_cfg_data;
                default: r_lat_div <= r_lat_div;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uvsig_pkg::PH_BODY_A;
            r_col   <= '0;
            r_band  <= '0;
            r_base  <= '0;
        end else if (in_accept) begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_band  <= n_band;
            r_base  <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_index_a <= idx_a;
            r_index_b <= idx_b;
            r_index_c <= idx_c;
            r_last    <= last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_index_a       = r_index_a;
    assign o_index_b       = r_index_b;
    assign o_index_c       = r_index_c;
    assign o_last_triangle = r_last;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted item produced no result");

    a_north_then_south: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_restart && r_phase == uvsig_pkg::PH_NORTH)
            |=> r_phase == uvsig_pkg::PH_SOUTH)
        else $error("north cap triangle not followed by south cap");

    a_last_clears_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_triangle)
            |-> (r_phase == uvsig_pkg::PH_BODY_A && r_col == '0 && r_band == '0
                 && r_base == '0))
        else $error("mesh counters not cleared after final triangle");

endmodule
